// ===== hdl/srg_pkg.sv =====
// Shared types and constants for the subtractive random generator.
// No dependencies; all other files but srg_ram use this package by scoped names.
`timescale 1ns / 1ps

package srg_pkg;

  // Table geometry: 56 entries, entry 0 unused, words kept as 32-bit two's complement
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 6;
  localparam int TBL_DEPTH = 56;
  localparam int MIX_PASSES = 4;

  localparam logic [IDX_W-1:0] TBL_LAST    = 6'd55;
  localparam logic [IDX_W-1:0] FILL_STEPS  = 6'd54;
  localparam logic [IDX_W-1:0] LAG_START   = 6'd21;
  localparam logic [IDX_W-1:0] FILL_STRIDE = 6'd21;
  localparam logic [IDX_W-1:0] MIX_OFFSET  = 6'd30;

  localparam logic [DATA_W-1:0] MAXV = 32'h7FFF_FFFF;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX  = 1'd1;
  localparam logic [30:0] MIX_CONST_RESET = 31'd161803398;

  // Result status codes
  localparam logic STAT_OK         = 1'b0;
  localparam logic STAT_BAD_BOUNDS = 1'b1;

  typedef enum logic [1:0] {
    CMD_RESEED  = 2'd0,
    CMD_RAW     = 2'd1,
    CMD_BOUNDED = 2'd2,
    CMD_BYTE    = 2'd3
  } cmd_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_RS_INIT,
    OP_RS_FILL,
    OP_MX_RD_I,
    OP_MX_RD_J,
    OP_MX_WR,
    OP_DR_RD_N,
    OP_DR_RD_L,
    OP_DR_WR,
    OP_BD_PREP,
    OP_BD_MUL,
    OP_BD_DIV1,
    OP_BD_DIV2,
    OP_RESULT
  } dp_op_t;

  // Which value the result register takes
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_RAW,
    RES_BYTE,
    RES_BOUNDED,
    RES_BAD
  } res_sel_t;

  typedef struct packed {
    logic     load;
    dp_op_t   op;
    res_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_bounds;
    logic wide_range;
    logic fill_last;
    logic mix_last;
  } dp_stat_t;

endpackage

// ===== hdl/subtractive_random_generator_core.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+----------------------------------------
// command   | start, busy (take: start&!busy) | cmd, low_bound, high_bound
// result    | done (one-cycle strobe)    | value, status
// config    | write_enable               | write_index, write_data
//
// A raw or byte draw runs dispatch, table RAM reads and a write, then the result
// state; a bounded draw adds prep, multiply and divide steps, with a second draw
// first when the range exceeds 2^31-1; inverted bounds skip the draw. The RAM is
// single-port. A reseed fills and mixes the table; an unseeded draw does so too.
// After rst no item has been taken and the table counts as unseeded.
// The receiver cannot stall: done is high for one cycle per result; value and status hold to the next.
//
// Top level of the subtractive random generator (55-word lagged table).
// Depends on srg_pkg, srg_ctrl, srg_dp and srg_ram.
`timescale 1ns / 1ps

module subtractive_random_generator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd,
  input  logic signed [srg_pkg::DATA_W-1:0] low_bound,
  input  logic signed [srg_pkg::DATA_W-1:0] high_bound,
  output logic                              done,
  output logic signed [srg_pkg::DATA_W-1:0] value,
  output logic                              status,
  input  logic                              write_enable,
  input  logic [srg_pkg::CFG_IDX_W-1:0]     write_index,
  input  logic [srg_pkg::DATA_W-1:0]        write_data
);

  srg_pkg::dp_cmd_t           dp_cmd;
  srg_pkg::dp_stat_t          dp_stat;
  logic [srg_pkg::DATA_W-1:0] value_u;

  srg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .dp_cmd (dp_cmd),
    .dp_stat(dp_stat)
  );

  srg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat),
    .low_bound   (low_bound),
    .high_bound  (high_bound),
    .write_enable(write_enable),
    .write_index (write_index),
    .write_data  (write_data),
    .value       (value_u),
    .status      (status)
  );

  assign value = value_u;

endmodule

// ===== hdl/srg_ram.sv =====
// Generic single-port RAM with registered read (read-before-write).
// No dependencies.
`timescale 1ns / 1ps

module srg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/srg_dp.sv =====
// Datapath: lagged table in RAM, seeding and draw arithmetic, bounded scaling.
// Depends on srg_pkg and srg_ram; driven by srg_ctrl through dp_cmd_t / dp_stat_t.
`timescale 1ns / 1ps

module srg_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  srg_pkg::dp_cmd_t                  dp_cmd,
  output srg_pkg::dp_stat_t                 dp_stat,
  input  logic signed [srg_pkg::DATA_W-1:0] low_bound,
  input  logic signed [srg_pkg::DATA_W-1:0] high_bound,
  input  logic                              write_enable,
  input  logic [srg_pkg::CFG_IDX_W-1:0]     write_index,
  input  logic [srg_pkg::DATA_W-1:0]        write_data,
  output logic [srg_pkg::DATA_W-1:0]        value,
  output logic                              status
);

  localparam logic [srg_pkg::IDX_W-1:0] MIX_FWD   = srg_pkg::MIX_OFFSET + 6'd1;
  localparam logic [srg_pkg::IDX_W-1:0] MIX_SPLIT =
    srg_pkg::TBL_LAST - srg_pkg::MIX_OFFSET - 6'd1;
  localparam logic [1:0] LAST_PASS = 2'(srg_pkg::MIX_PASSES - 1);
  // Divisor pieces: 2^31-1 for narrow ranges, 4*(2^30-1) for wide ranges
  localparam logic [32:0] MAXV_X1  = {1'b0, srg_pkg::MAXV};
  localparam logic [32:0] MAXV_X2  = {srg_pkg::MAXV, 1'b0};
  localparam logic [30:0] K30      = 31'h3FFF_FFFF;
  localparam logic [31:0] WIDE_OFS = srg_pkg::MAXV - 32'd1;

  function automatic logic [31:0] fold(input logic [31:0] x);
    return x[31] ? x + srg_pkg::MAXV : x;
  endfunction

  // Control and configuration state
  logic [31:0] seed;
  logic [30:0] mix_constant;
  logic [5:0]  cnt;
  logic [1:0]  pass;
  logic [5:0]  ii;
  logic [5:0]  nidx;
  logic [5:0]  lidx;

  // Payload registers
  logic [31:0] lo_q;
  logic [31:0] range_q;
  logic        bad_q;
  logic        wide_q;
  logic [31:0] mj;
  logic [31:0] mk;
  logic [31:0] tmp;
  logic [31:0] d;
  logic [31:0] dprev;
  logic [31:0] opnd;
  logic        neg;
  logic [63:0] prod;
  logic [31:0] qa;
  logic [32:0] s1;
  logic [31:0] q;
  logic [31:0] value_r;
  logic        status_r;

  // Memory port
  logic        ram_we;
  logic [5:0]  ram_addr;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;

  // Combinational helpers
  logic [31:0] seed_mag;
  logic [31:0] mj_init;
  logic [6:0]  ii_sum;
  logic [5:0]  ii_next;
  logic [5:0]  j_idx;
  logic [5:0]  n_step;
  logic [5:0]  l_step;
  logic [31:0] diff;
  logic [31:0] draw_val;
  logic [32:0] bound_diff;
  logic [31:0] wide_r;
  logic [30:0] s2;
  logic [31:0] q_signed;

  srg_ram #(
    .WIDTH(srg_pkg::DATA_W),
    .DEPTH(srg_pkg::TBL_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Seeding and index arithmetic
  always_comb begin
    if (seed == 32'h8000_0000) begin
      seed_mag = srg_pkg::MAXV;
    end else begin
      seed_mag = seed[31] ? 32'd0 - seed : seed;
    end
    mj_init = {1'b0, mix_constant} - seed_mag;
    ii_sum  = {1'b0, ii} + {1'b0, srg_pkg::FILL_STRIDE};
    ii_next = (ii_sum >= {1'b0, srg_pkg::TBL_LAST}) ?
              6'(ii_sum - {1'b0, srg_pkg::TBL_LAST}) : ii_sum[5:0];
    j_idx   = (cnt <= MIX_SPLIT) ? cnt + MIX_FWD : cnt - MIX_SPLIT;
    n_step  = (nidx == srg_pkg::TBL_LAST) ? 6'd1 : nidx + 6'd1;
    l_step  = (lidx == srg_pkg::TBL_LAST) ? 6'd1 : lidx + 6'd1;
  end

  // Draw: difference, nudge off 2^31-1, fold
  always_comb begin
    diff     = tmp - ram_rdata;
    draw_val = fold((diff == srg_pkg::MAXV) ? diff - 32'd1 : diff);
  end

  // Range check on the incoming bounds
  assign bound_diff = {high_bound[31], high_bound} - {low_bound[31], low_bound};

  // Wide range: first draw, negated when the second draw is even
  assign wide_r   = d[0] ? dprev : 32'd0 - dprev;
  assign s2       = {28'd0, s1[32:30]} + {1'b0, s1[29:0]};
  assign q_signed = neg ? 32'd0 - q : q;

  // Memory port select
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cnt;
    ram_wdata = mk;
    case (dp_cmd.op)
      srg_pkg::OP_RS_INIT: begin
        ram_we    = 1'b1;
        ram_addr  = srg_pkg::TBL_LAST;
        ram_wdata = mj_init;
      end
      srg_pkg::OP_RS_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = ii;
        ram_wdata = mk;
      end
      srg_pkg::OP_MX_RD_I: ram_addr = cnt;
      srg_pkg::OP_MX_RD_J: ram_addr = j_idx;
      srg_pkg::OP_MX_WR: begin
        ram_we    = 1'b1;
        ram_addr  = cnt;
        ram_wdata = fold(diff);
      end
      srg_pkg::OP_DR_RD_N: ram_addr = n_step;
      srg_pkg::OP_DR_RD_L: ram_addr = l_step;
      srg_pkg::OP_DR_WR: begin
        ram_we    = 1'b1;
        ram_addr  = nidx;
        ram_wdata = draw_val;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Config registers, counters and indices
  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= '0;
      mix_constant <= srg_pkg::MIX_CONST_RESET;
      cnt          <= 6'd1;
      pass         <= '0;
      ii           <= srg_pkg::FILL_STRIDE;
      nidx         <= '0;
      lidx         <= srg_pkg::LAG_START;
    end else begin
      if (write_enable) begin
        case (write_index)
          srg_pkg::REG_SEED: seed <= write_data;
          srg_pkg::REG_MIX:  mix_constant <= write_data[30:0];
          default: ;
        endcase
      end
      case (dp_cmd.op)
        srg_pkg::OP_RS_INIT: begin
          cnt  <= 6'd1;
          pass <= '0;
          ii   <= srg_pkg::FILL_STRIDE;
          nidx <= '0;
          lidx <= srg_pkg::LAG_START;
        end
        srg_pkg::OP_RS_FILL: begin
          ii  <= ii_next;
          cnt <= (cnt == srg_pkg::FILL_STEPS) ? 6'd1 : cnt + 6'd1;
        end
        srg_pkg::OP_MX_WR: begin
          if (cnt == srg_pkg::TBL_LAST) begin
            cnt  <= 6'd1;
            pass <= pass + 2'd1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        srg_pkg::OP_DR_RD_N: nidx <= n_step;
        srg_pkg::OP_DR_RD_L: lidx <= l_step;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      lo_q    <= low_bound;
      range_q <= bound_diff[31:0];
      bad_q   <= bound_diff[32];
      wide_q  <= bound_diff[31];
    end
    case (dp_cmd.op)
      srg_pkg::OP_RS_INIT: begin
        mj <= mj_init;
        mk <= 32'd1;
      end
      srg_pkg::OP_RS_FILL: begin
        mj <= mk;
        mk <= fold(mj - mk);
      end
      srg_pkg::OP_MX_RD_J: tmp <= ram_rdata;
      srg_pkg::OP_DR_RD_L: tmp <= ram_rdata;
      srg_pkg::OP_DR_WR: begin
        dprev <= d;
        d     <= draw_val;
      end
      srg_pkg::OP_BD_PREP: begin
        if (wide_q) begin
          opnd <= wide_r + WIDE_OFS;
          neg  <= 1'b0;
        end else begin
          opnd <= d[31] ? 32'd0 - d : d;
          neg  <= d[31];
        end
      end
      srg_pkg::OP_BD_MUL: prod <= opnd * range_q;
      srg_pkg::OP_BD_DIV1: begin
        // N = a*2^k + b  ->  N = a*(2^k-1) + (a+b)
        if (wide_q) begin
          qa <= prod[63:32];
          s1 <= {1'b0, prod[63:32]} + {3'd0, prod[31:2]};
        end else begin
          qa <= {1'b0, prod[61:31]};
          s1 <= {2'd0, prod[61:31]} + {2'd0, prod[30:0]};
        end
      end
      srg_pkg::OP_BD_DIV2: begin
        if (wide_q) begin
          q <= qa + {29'd0, s1[32:30]} + {31'd0, (s2 >= K30)};
        end else if (s1 >= MAXV_X2) begin
          q <= qa + 32'd2;
        end else if (s1 >= MAXV_X1) begin
          q <= qa + 32'd1;
        end else begin
          q <= qa;
        end
      end
      srg_pkg::OP_RESULT: begin
        case (dp_cmd.sel)
          srg_pkg::RES_RAW: begin
            value_r  <= d;
            status_r <= srg_pkg::STAT_OK;
          end
          srg_pkg::RES_BYTE: begin
            value_r  <= {24'd0, d[7:0]};
            status_r <= srg_pkg::STAT_OK;
          end
          srg_pkg::RES_BOUNDED: begin
            value_r  <= lo_q + q_signed;
            status_r <= srg_pkg::STAT_OK;
          end
          srg_pkg::RES_BAD: begin
            value_r  <= '0;
            status_r <= srg_pkg::STAT_BAD_BOUNDS;
          end
          default: begin
            value_r  <= '0;
            status_r <= srg_pkg::STAT_OK;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Status to the controller
  always_comb begin
    dp_stat.bad_bounds = bad_q;
    dp_stat.wide_range = wide_q;
    dp_stat.fill_last  = (cnt == srg_pkg::FILL_STEPS);
    dp_stat.mix_last   = (cnt == srg_pkg::TBL_LAST) && (pass == LAST_PASS);
  end

  assign value  = value_r;
  assign status = status_r;

endmodule

// ===== hdl/srg_ctrl.sv =====
// Controller: sequences reseed, table mixing, draws and bounded scaling.
// Depends on srg_pkg; commands srg_dp through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module srg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        cmd,
  output logic              busy,
  output logic              done,
  output srg_pkg::dp_cmd_t  dp_cmd,
  input  srg_pkg::dp_stat_t dp_stat
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RS_INIT,
    ST_RS_FILL,
    ST_MX_RD_I,
    ST_MX_RD_J,
    ST_MX_WR,
    ST_DISPATCH,
    ST_DR_RD_N,
    ST_DR_RD_L,
    ST_DR_WR,
    ST_BD_PREP,
    ST_BD_MUL,
    ST_BD_DIV1,
    ST_BD_DIV2,
    ST_FIN
  } state_t;

  state_t            state;
  srg_pkg::cmd_t     cmd_q;
  srg_pkg::cmd_t     cmd_in;
  srg_pkg::res_sel_t sel;
  logic              seeded;
  logic              second;

  assign cmd_in = srg_pkg::cmd_t'(cmd);
  assign busy   = (state != ST_IDLE);

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cmd_q  <= srg_pkg::CMD_RESEED;
      sel    <= srg_pkg::RES_ZERO;
      seeded <= 1'b0;
      second <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd_in;
            // a draw before the first reseed seeds the table first
            if (cmd_in == srg_pkg::CMD_RESEED || !seeded) begin
              state <= ST_RS_INIT;
            end else begin
              state <= ST_DISPATCH;
            end
          end
        end
        ST_RS_INIT: state <= ST_RS_FILL;
        ST_RS_FILL: begin
          if (dp_stat.fill_last) begin
            state <= ST_MX_RD_I;
          end
        end
        ST_MX_RD_I: state <= ST_MX_RD_J;
        ST_MX_RD_J: state <= ST_MX_WR;
        ST_MX_WR: begin
          if (dp_stat.mix_last) begin
            seeded <= 1'b1;
            if (cmd_q == srg_pkg::CMD_RESEED) begin
              sel   <= srg_pkg::RES_ZERO;
              state <= ST_FIN;
            end else begin
              state <= ST_DISPATCH;
            end
          end else begin
            state <= ST_MX_RD_I;
          end
        end
        ST_DISPATCH: begin
          case (cmd_q)
            srg_pkg::CMD_RAW: begin
              sel   <= srg_pkg::RES_RAW;
              state <= ST_DR_RD_N;
            end
            srg_pkg::CMD_BYTE: begin
              sel   <= srg_pkg::RES_BYTE;
              state <= ST_DR_RD_N;
            end
            srg_pkg::CMD_BOUNDED: begin
              if (dp_stat.bad_bounds) begin
                sel   <= srg_pkg::RES_BAD;
                state <= ST_FIN;
              end else begin
                sel    <= srg_pkg::RES_BOUNDED;
                second <= dp_stat.wide_range;
                state  <= ST_DR_RD_N;
              end
            end
            default: begin
              sel   <= srg_pkg::RES_ZERO;
              state <= ST_FIN;
            end
          endcase
        end
        ST_DR_RD_N: state <= ST_DR_RD_L;
        ST_DR_RD_L: state <= ST_DR_WR;
        ST_DR_WR: begin
          if (sel == srg_pkg::RES_BOUNDED) begin
            // wide ranges take a second draw for the sign
            if (second) begin
              second <= 1'b0;
              state  <= ST_DR_RD_N;
            end else begin
              state <= ST_BD_PREP;
            end
          end else begin
            state <= ST_FIN;
          end
        end
        ST_BD_PREP: state <= ST_BD_MUL;
        ST_BD_MUL:  state <= ST_BD_DIV1;
        ST_BD_DIV1: state <= ST_BD_DIV2;
        ST_BD_DIV2: state <= ST_FIN;
        ST_FIN: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath operation per state
  always_comb begin
    dp_cmd.load = (state == ST_IDLE) && start;
    dp_cmd.sel  = sel;
    case (state)
      ST_RS_INIT: dp_cmd.op = srg_pkg::OP_RS_INIT;
      ST_RS_FILL: dp_cmd.op = srg_pkg::OP_RS_FILL;
      ST_MX_RD_I: dp_cmd.op = srg_pkg::OP_MX_RD_I;
      ST_MX_RD_J: dp_cmd.op = srg_pkg::OP_MX_RD_J;
      ST_MX_WR:   dp_cmd.op = srg_pkg::OP_MX_WR;
      ST_DR_RD_N: dp_cmd.op = srg_pkg::OP_DR_RD_N;
      ST_DR_RD_L: dp_cmd.op = srg_pkg::OP_DR_RD_L;
      ST_DR_WR:   dp_cmd.op = srg_pkg::OP_DR_WR;
      ST_BD_PREP: dp_cmd.op = srg_pkg::OP_BD_PREP;
      ST_BD_MUL:  dp_cmd.op = srg_pkg::OP_BD_MUL;
      ST_BD_DIV1: dp_cmd.op = srg_pkg::OP_BD_DIV1;
      ST_BD_DIV2: dp_cmd.op = srg_pkg::OP_BD_DIV2;
      ST_FIN:     dp_cmd.op = srg_pkg::OP_RESULT;
      default:    dp_cmd.op = srg_pkg::OP_IDLE;
    endcase
  end

endmodule

// ===== hdl/srg_checker.sv =====
// Port-level checks on the generator core, attached by bind.
// Depends on subtractive_random_generator_core's port list and srg_pkg.
`timescale 1ns / 1ps

module srg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [srg_pkg::DATA_W-1:0] value,
  input logic                              status
);

  // A taken item keeps the core busy in the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item taken but core not busy");

  // The result strobe is never high twice in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // Busy only drops together with a result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == srg_pkg::STAT_BAD_BOUNDS) |-> (value == '0))
    else $error("bound error with nonzero value");

endmodule

bind subtractive_random_generator_core srg_checker u_srg_checker (.*);
